[rtl/lpidl_pkg.sv]
package lpidl_pkg;

	// Result kinds, carried on the master-side tuser.
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_TITLE   = 3'd0;
	localparam kind_t KIND_DATE    = 3'd1;
	localparam kind_t KIND_DBDATE  = 3'd2;
	localparam kind_t KIND_NAMES   = 3'd3;
	localparam kind_t KIND_ID      = 3'd4;
	localparam kind_t KIND_IDCOUNT = 3'd5;
	localparam kind_t KIND_VOLLEN  = 3'd6;
	localparam kind_t KIND_STATUS  = 3'd7;

	// Status codes of a status result.
	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_SIZE     = 3'd1;
	localparam status_t ST_IDCOUNT  = 3'd2;
	localparam status_t ST_LEGACY   = 3'd3;
	localparam status_t ST_TRUNC    = 3'd4;

	// A one-byte id length of this value announces a four-byte length.
	localparam logic [7:0] ESCAPE_LEN = 8'hFF;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic [31:0] id_index;
		logic        last_of_field;
		logic        empty_field;
		status_t     status;
	} result_t;

	// Up to two results are written into the result queue per byte.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic valid;
		logic room2;
	} qstat_t;

endpackage

[rtl/length_prefixed_id_list_parser.sv]
// Identifier-list file parser. File bytes arrive one per slave-side transaction,
// with tlast on the final byte of a file. A first byte of zero selects the
// versioned header, which is checked against the expected_file_size register
// and taken apart into title, date, id count, volume length, db date and volume
// names; the ids follow, each behind a one-byte length (0xFF escapes to a
// four-byte little-endian length). Every string byte goes out as one master-side
// transaction, and a status transaction closes each file. The block takes one
// byte per clock cycle while the result queue has room for two results: the byte
// is held in an input register, the parser state machine advances from it, and
// its results enter a four-entry result queue and pass from there to the master
// side. Only the final byte of a file can produce two results; the slave side
// stalls only while the master side does not take results.
// Write expected_file_size only between files.
module length_prefixed_id_list_parser
	import lpidl_pkg::*;
#(
	parameter int unsigned ID_COUNT_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: expected_file_size.
	input  logic         cfg_we,
	input  logic [63:0]  cfg_wdata,
	// Slave side: tdata[7:0] data_byte; tlast is last_byte.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	// Master side: tdata[63:0] value, [95:64] id_index, [96] last_of_field,
	// [97] empty_field, [100:98] status, [103:101] zero; tuser[2:0] kind.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,
	output logic [2:0]   m_tuser
);

	typedef enum logic [3:0] {
		PH_FORMAT, PH_SIZE, PH_COUNT, PH_TITLE_LEN, PH_TITLE, PH_DATE_LEN,
		PH_DATE, PH_VOL_LEN, PH_DBDATE_LEN, PH_DBDATE, PH_NAMES_LEN, PH_NAMES,
		PH_ID_LEN, PH_ID_LONGLEN, PH_ID_BYTES, PH_DONE
	} phase_t;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Parser state.
	phase_t                   phase_q, phase_n;
	logic [2:0]               byte_in_word_q, byte_in_word_n;
	logic [63:0]              word_gather_q, word_gather_n;
	logic [31:0]              bytes_left_q, bytes_left_n;
	logic [63:0]              ids_expected_q, ids_expected_n;
	logic [ID_COUNT_BITS-1:0] ids_seen_q, ids_seen_n;
	logic [63:0]              expected_size_q;

	logic        proc;
	qstat_t      qst;
	result_t     head;
	push_t       push;

	logic [63:0] wg_acc;
	logic [2:0]  biw_inc;
	logic [63:0] seen_ext, seen_n_ext;
	logic        has_a;
	result_t     res_a, res_st;
	logic        start_str, start_id, bump, endf;
	phase_t      str_ph;
	logic [31:0] new_len;

	function automatic result_t mk(kind_t k, logic [63:0] v, logic [31:0] idx,
	                               logic lf, logic ef, status_t s);
		result_t r;
		r.kind          = k;
		r.value         = v;
		r.id_index      = idx;
		r.last_of_field = lf;
		r.empty_field   = ef;
		r.status        = s;
		return r;
	endfunction

	function automatic kind_t str_kind(phase_t p);
		case (p)
			PH_TITLE:  return KIND_TITLE;
			PH_DATE:   return KIND_DATE;
			PH_DBDATE: return KIND_DBDATE;
			default:   return KIND_NAMES;
		endcase
	endfunction

	function automatic phase_t str_next(phase_t p);
		case (p)
			PH_TITLE:  return PH_DATE_LEN;
			PH_DATE:   return PH_VOL_LEN;
			PH_DBDATE: return PH_NAMES_LEN;
			default:   return PH_ID_LEN;
		endcase
	endfunction

	// The held byte is processed once the queue can absorb two results.
	assign proc     = valid_s1 && qst.room2;
	assign s_tready = !valid_s1 || qst.room2;

	assign seen_ext = 64'(ids_seen_q);
	assign wg_acc   = word_gather_q | (64'(byte_s1) << {byte_in_word_q, 3'b000});
	assign biw_inc  = byte_in_word_q + 3'd1;
	assign endf     = (bytes_left_q <= 32'd1);

	always_comb begin
		phase_n        = phase_q;
		byte_in_word_n = byte_in_word_q;
		word_gather_n  = word_gather_q;
		bytes_left_n   = bytes_left_q;
		ids_expected_n = ids_expected_q;
		has_a          = 1'b0;
		res_a          = '0;
		start_str      = 1'b0;
		start_id       = 1'b0;
		bump           = 1'b0;
		str_ph         = PH_TITLE;
		new_len        = '0;

		case (phase_q)
			PH_FORMAT: begin
				if (byte_s1 != 8'd0) begin
					has_a   = 1'b1;
					res_a   = mk(KIND_STATUS, '0, '0, 1'b0, 1'b0, ST_LEGACY);
					phase_n = PH_DONE;
				end else begin
					word_gather_n  = '0;
					byte_in_word_n = '0;
					phase_n        = PH_SIZE;
				end
			end
			PH_SIZE, PH_COUNT, PH_VOL_LEN: begin
				word_gather_n  = wg_acc;
				byte_in_word_n = biw_inc;
				if (byte_in_word_q == 3'd7) begin
					byte_in_word_n = '0;
					word_gather_n  = '0;
					if (phase_q == PH_SIZE) begin
						if (wg_acc != expected_size_q) begin
							has_a   = 1'b1;
							res_a   = mk(KIND_STATUS, '0, '0, 1'b0, 1'b0, ST_SIZE);
							phase_n = PH_DONE;
						end else begin
							phase_n = PH_COUNT;
						end
					end else if (phase_q == PH_COUNT) begin
						ids_expected_n = wg_acc;
						has_a          = 1'b1;
						res_a          = mk(KIND_IDCOUNT, wg_acc, '0, 1'b0, 1'b0, ST_OK);
						phase_n        = PH_TITLE_LEN;
					end else begin
						has_a   = 1'b1;
						res_a   = mk(KIND_VOLLEN, wg_acc, '0, 1'b0, 1'b0, ST_OK);
						phase_n = (wg_acc != 64'd0) ? PH_DBDATE_LEN : PH_ID_LEN;
					end
				end
			end
			PH_TITLE_LEN, PH_NAMES_LEN, PH_ID_LONGLEN: begin
				word_gather_n  = wg_acc;
				byte_in_word_n = biw_inc;
				if (byte_in_word_q == 3'd3) begin
					byte_in_word_n = '0;
					word_gather_n  = '0;
					new_len        = wg_acc[31:0];
					if (phase_q == PH_ID_LONGLEN) begin
						start_id = 1'b1;
					end else begin
						start_str = 1'b1;
						str_ph    = (phase_q == PH_TITLE_LEN) ? PH_TITLE : PH_NAMES;
					end
				end
			end
			PH_DATE_LEN, PH_DBDATE_LEN: begin
				start_str = 1'b1;
				new_len   = 32'(byte_s1);
				str_ph    = (phase_q == PH_DATE_LEN) ? PH_DATE : PH_DBDATE;
			end
			PH_TITLE, PH_DATE, PH_DBDATE, PH_NAMES: begin
				has_a        = 1'b1;
				res_a        = mk(str_kind(phase_q), 64'(byte_s1), '0, endf, 1'b0, ST_OK);
				bytes_left_n = bytes_left_q - 32'd1;
				if (endf) begin
					bytes_left_n = '0;
					phase_n      = str_next(phase_q);
				end
			end
			PH_ID_LEN: begin
				// Once every announced id is seen, further bytes are dropped.
				if (seen_ext < ids_expected_q) begin
					if (byte_s1 == ESCAPE_LEN) begin
						word_gather_n  = '0;
						byte_in_word_n = '0;
						phase_n        = PH_ID_LONGLEN;
					end else begin
						start_id = 1'b1;
						new_len  = 32'(byte_s1);
					end
				end
			end
			PH_ID_BYTES: begin
				has_a        = 1'b1;
				res_a        = mk(KIND_ID, 64'(byte_s1), seen_ext[31:0], endf, 1'b0, ST_OK);
				bytes_left_n = bytes_left_q - 32'd1;
				if (endf) begin
					bytes_left_n = '0;
					bump         = 1'b1;
					phase_n      = PH_ID_LEN;
				end
			end
			default: begin
			end
		endcase

		if (start_str) begin
			if (new_len == 32'd0) begin
				has_a   = 1'b1;
				res_a   = mk(str_kind(str_ph), '0, '0, 1'b0, 1'b1, ST_OK);
				phase_n = str_next(str_ph);
			end else begin
				bytes_left_n = new_len;
				phase_n      = str_ph;
			end
		end

		if (start_id) begin
			if (new_len == 32'd0) begin
				has_a   = 1'b1;
				res_a   = mk(KIND_ID, '0, seen_ext[31:0], 1'b0, 1'b1, ST_OK);
				bump    = 1'b1;
				phase_n = PH_ID_LEN;
			end else begin
				bytes_left_n = new_len;
				phase_n      = PH_ID_BYTES;
			end
		end

		// The id counter saturates at its top value.
		ids_seen_n = ids_seen_q;
		if (phase_q == PH_COUNT && byte_in_word_q == 3'd7) begin
			ids_seen_n = '0;
		end else if (bump && ids_seen_q != '1) begin
			ids_seen_n = ids_seen_q + ID_COUNT_BITS'(1);
		end
		seen_n_ext = 64'(ids_seen_n);

		// End of file: report a status unless one was given, then restart.
		res_st    = '0;
		push      = '0;
		if (last_s1 && phase_n != PH_DONE) begin
			if (phase_n == PH_ID_LEN) begin
				res_st = mk(KIND_STATUS, '0, '0, 1'b0, 1'b0,
				            (seen_n_ext == ids_expected_n) ? ST_OK : ST_IDCOUNT);
			end else begin
				res_st = mk(KIND_STATUS, '0, '0, 1'b0, 1'b0, ST_TRUNC);
			end
			if (has_a) begin
				push.n  = 2'd2;
				push.r0 = res_a;
				push.r1 = res_st;
			end else begin
				push.n  = 2'd1;
				push.r0 = res_st;
			end
		end else if (has_a) begin
			push.n  = 2'd1;
			push.r0 = res_a;
		end
		if (!proc) begin
			push.n = 2'd0;
		end

		if (last_s1) begin
			phase_n        = PH_FORMAT;
			byte_in_word_n = '0;
			word_gather_n  = '0;
			bytes_left_n   = '0;
			ids_expected_n = '0;
			ids_seen_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_size_q <= '0;
		end else if (cfg_we) begin
			expected_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_FORMAT;
			byte_in_word_q <= '0;
			word_gather_q  <= '0;
			bytes_left_q   <= '0;
			ids_expected_q <= '0;
			ids_seen_q     <= '0;
		end else if (proc) begin
			phase_q        <= phase_n;
			byte_in_word_q <= byte_in_word_n;
			word_gather_q  <= word_gather_n;
			bytes_left_q   <= bytes_left_n;
			ids_expected_q <= ids_expected_n;
			ids_seen_q     <= ids_seen_n;
		end
	end

	lpidl_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (m_tready),
		.head   (head),
		.st     (qst)
	);

	assign m_tvalid = qst.valid;
	assign m_tdata  = {3'b000, head.status, head.empty_field, head.last_of_field,
	                   head.id_index, head.value};
	assign m_tuser  = head.kind;

	// A file start always finds the word gatherer cleared.
	a_format_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FORMAT) |-> (word_gather_q == 64'd0 && byte_in_word_q == 3'd0))
		else $error("word gatherer not clear at file start");

	// Inside an id or a string there is always at least one byte left.
	a_bytes_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ID_BYTES || phase_q == PH_TITLE || phase_q == PH_DATE ||
		 phase_q == PH_DBDATE || phase_q == PH_NAMES) |-> (bytes_left_q != 32'd0))
		else $error("string phase with no bytes left");

	// Two results from one byte only at the end of a file, the second a status.
	a_pair_status: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (proc && last_s1 && push.r1.kind == KIND_STATUS))
		else $error("result pair without closing status");

	// A processed byte never overfills the result queue.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> qst.room2)
		else $error("result queue overrun");

endmodule

[rtl/lpidl_rq.sv]
module lpidl_rq
	import lpidl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output result_t head,
	output qstat_t  st
);

	localparam int DEPTH = 4;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	result_t        mem [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           pop_ok;

	assign pop_ok   = pop && (cnt_q != '0);
	assign head     = mem[rd_ptr_q];
	assign st.valid = (cnt_q != '0);
	assign st.room2 = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_ptr_q + PW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.n);
			rd_ptr_q <= rd_ptr_q + PW'(pop_ok);
			cnt_q    <= cnt_q + CW'(push.n) - CW'(pop_ok);
		end
	end

endmodule

[tb/id_list_parse_checker.sv]
`timescale 1ns / 100ps

// Watches both streams of the parser and predicts every result
// transaction from the accepted file bytes.
module id_list_parse_checker
	import lpidl_pkg::*;
#(
	parameter int unsigned ID_COUNT_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [63:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic [2:0]   m_tuser,
	output int           open_results,
	output int           fail_count
);

	typedef enum logic [3:0] {
		P_FORMAT, P_SIZE, P_COUNT, P_TITLE_LEN, P_TITLE, P_DATE_LEN, P_DATE, P_VOL_LEN,
		P_DBDATE_LEN, P_DBDATE, P_NAMES_LEN, P_NAMES, P_ID_LEN, P_ID_LONGLEN, P_ID_BYTES,
		P_DONE
	} parse_phase_t;

	localparam logic [63:0] ID_SEEN_MAX =
		(ID_COUNT_BITS >= 64) ? '1 : ((64'd1 << ID_COUNT_BITS) - 64'd1);

	parse_phase_t ph;
	logic [2:0]   word_pos;
	logic [63:0]  word_acc;
	logic [31:0]  str_left;
	logic [63:0]  id_total;
	logic [63:0]  id_seen;
	logic         vol_present;
	logic [63:0]  file_size_reg;

	result_t parsed_fields_q[$];

	function automatic kind_t kind_of_string(parse_phase_t p);
		case (p)
			P_TITLE:  return KIND_TITLE;
			P_DATE:   return KIND_DATE;
			P_DBDATE: return KIND_DBDATE;
			default:  return KIND_NAMES;
		endcase
	endfunction

	function automatic parse_phase_t phase_after_string(parse_phase_t p);
		case (p)
			P_TITLE:  return P_DATE_LEN;
			P_DATE:   return P_VOL_LEN;
			P_DBDATE: return P_NAMES_LEN;
			default:  return P_ID_LEN;
		endcase
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			fail_count++;
		end
	endfunction

	task automatic push_result(kind_t k, logic [63:0] v, logic [31:0] idx, logic lf,
			logic ef, status_t st);
		result_t r;
		r.kind = k;
		r.value = v;
		r.id_index = idx;
		r.last_of_field = lf;
		r.empty_field = ef;
		r.status = st;
		parsed_fields_q.push_back(r);
	endtask

	task automatic restart_file();
		ph = P_FORMAT;
		word_pos = '0;
		word_acc = '0;
		str_left = '0;
		id_total = '0;
		id_seen = '0;
		vol_present = 1'b0;
	endtask

	// Little-endian word assembly; a count of eight wraps the 3-bit position to zero.
	task automatic gather_byte(input logic [7:0] b, input int nbytes, output logic done);
		word_acc |= 64'(b) << (8 * word_pos);
		word_pos = word_pos + 3'd1;
		done = (word_pos == 3'(nbytes));
		if (done)
			word_pos = '0;
	endtask

	task automatic count_id();
		if (id_seen < ID_SEEN_MAX)
			id_seen++;
	endtask

	task automatic open_string(parse_phase_t p, logic [31:0] len);
		if (len == 0) begin
			push_result(kind_of_string(p), '0, '0, 1'b0, 1'b1, ST_OK);
			ph = phase_after_string(p);
		end else begin
			str_left = len;
			ph = p;
		end
	endtask

	task automatic open_id(logic [31:0] len);
		if (len == 0) begin
			push_result(KIND_ID, '0, id_seen[31:0], 1'b0, 1'b1, ST_OK);
			count_id();
			ph = P_ID_LEN;
		end else begin
			str_left = len;
			ph = P_ID_BYTES;
		end
	endtask

	task automatic parse_file_byte(input logic [7:0] b, input logic last);
		logic        done;
		logic        endf;
		logic [31:0] len;
		status_t     st;
		case (ph)
			P_FORMAT: begin
				if (b != 8'd0) begin
					push_result(KIND_STATUS, '0, '0, 1'b0, 1'b0, ST_LEGACY);
					ph = P_DONE;
				end else begin
					word_acc = '0;
					word_pos = '0;
					ph = P_SIZE;
				end
			end
			P_SIZE: begin
				gather_byte(b, 8, done);
				if (done) begin
					if (word_acc != file_size_reg) begin
						push_result(KIND_STATUS, '0, '0, 1'b0, 1'b0, ST_SIZE);
						ph = P_DONE;
					end else begin
						ph = P_COUNT;
					end
					word_acc = '0;
				end
			end
			P_COUNT: begin
				gather_byte(b, 8, done);
				if (done) begin
					id_total = word_acc;
					id_seen = '0;
					push_result(KIND_IDCOUNT, word_acc, '0, 1'b0, 1'b0, ST_OK);
					word_acc = '0;
					ph = P_TITLE_LEN;
				end
			end
			P_TITLE_LEN, P_NAMES_LEN: begin
				gather_byte(b, 4, done);
				if (done) begin
					len = word_acc[31:0];
					word_acc = '0;
					open_string((ph == P_TITLE_LEN) ? P_TITLE : P_NAMES, len);
				end
			end
			P_DATE_LEN:   open_string(P_DATE, 32'(b));
			P_DBDATE_LEN: open_string(P_DBDATE, 32'(b));
			P_TITLE, P_DATE, P_DBDATE, P_NAMES: begin
				endf = (str_left <= 1);
				push_result(kind_of_string(ph), 64'(b), '0, endf, 1'b0, ST_OK);
				str_left--;
				if (endf) begin
					str_left = '0;
					ph = phase_after_string(ph);
				end
			end
			P_VOL_LEN: begin
				gather_byte(b, 8, done);
				if (done) begin
					push_result(KIND_VOLLEN, word_acc, '0, 1'b0, 1'b0, ST_OK);
					vol_present = (word_acc != 0);
					word_acc = '0;
					ph = vol_present ? P_DBDATE_LEN : P_ID_LEN;
				end
			end
			P_ID_LEN: begin
				// Once the announced number of ids is in, further bytes are dropped.
				if (id_seen < id_total) begin
					if (b == ESCAPE_LEN) begin
						word_acc = '0;
						word_pos = '0;
						ph = P_ID_LONGLEN;
					end else begin
						open_id(32'(b));
					end
				end
			end
			P_ID_LONGLEN: begin
				gather_byte(b, 4, done);
				if (done) begin
					len = word_acc[31:0];
					word_acc = '0;
					open_id(len);
				end
			end
			P_ID_BYTES: begin
				endf = (str_left <= 1);
				push_result(KIND_ID, 64'(b), id_seen[31:0], endf, 1'b0, ST_OK);
				str_left--;
				if (endf) begin
					str_left = '0;
					count_id();
					ph = P_ID_LEN;
				end
			end
			default: ;
		endcase

		if (last) begin
			if (ph != P_DONE) begin
				if (ph == P_ID_LEN)
					st = (id_seen == id_total) ? ST_OK : ST_IDCOUNT;
				else
					st = ST_TRUNC;
				push_result(KIND_STATUS, '0, '0, 1'b0, 1'b0, st);
			end
			restart_file();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			restart_file();
			file_size_reg = '0;
			parsed_fields_q.delete();
			fail_count = 0;
			open_results <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (parsed_fields_q.size() == 0) begin
					$error("result transaction with nothing expected: kind %0d, tdata %h",
						m_tuser, m_tdata);
					fail_count++;
				end else begin
					want = parsed_fields_q.pop_front();
					check_field("kind", 64'(want.kind), 64'(m_tuser));
					check_field("value", want.value, m_tdata[63:0]);
					check_field("id_index", 64'(want.id_index), 64'(m_tdata[95:64]));
					check_field("last_of_field", 64'(want.last_of_field), 64'(m_tdata[96]));
					check_field("empty_field", 64'(want.empty_field), 64'(m_tdata[97]));
					check_field("status", 64'(want.status), 64'(m_tdata[100:98]));
					check_field("tdata padding", 64'd0, 64'(m_tdata[103:101]));
				end
			end
			if (cfg_we)
				file_size_reg = cfg_wdata;
			if (s_tvalid && s_tready)
				parse_file_byte(s_tdata, s_tlast);
			open_results <= parsed_fields_q.size();
		end
	end

endmodule

[tb/tb_length_prefixed_id_list_parser.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the identifier-list parser. Whole files are built
// byte by byte in a queue and then streamed into the slave side; the checker
// instantiated beside the block predicts and compares every result
// transaction. The expected_file_size register is only rewritten while the
// parser is idle, so a file that needs a new setting first waits for all
// outstanding results to drain.
module tb_length_prefixed_id_list_parser;
	import lpidl_pkg::*;

	localparam int RANDOM_BYTES = 600;
	// Cycles with neither a slave-side nor a master-side transaction before the
	// run is declared hung. Sender gaps and receiver stalls are far shorter.
	localparam int QUIET_LIMIT = 2000;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we;
	logic [63:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic [2:0]   m_tuser;

	int open_results;
	int fail_count;

	// File under construction, the register value currently in the block
	// (unknown until the first write) and the sender's burst state.
	logic [7:0]  file_bytes[$];
	logic [63:0] size_setting;
	int          burst_left = 0;
	int          bytes_sent = 0;
	int          quiet_cycles = 0;
	int          rx_span = 0;
	rx_mode_t    rx_mode = RX_FREE;

	length_prefixed_id_list_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	id_list_parse_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.open_results(open_results),
		.fail_count(fail_count)
	);

	always #2 clk = ~clk;

	// The receiver switches between free-running, lightly stalled and heavily
	// stalled stretches, each lasting a random number of cycles.
	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_span <= $urandom_range(16, 96);
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
		end else begin
			rx_span <= rx_span - 1;
		end
		case (rx_mode)
			RX_FREE:  m_tready <= 1'b1;
			RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
			default:  m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Any transaction on either side shows the block is alive.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int pick_len(int hi);
		return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, hi);
	endfunction

	task automatic put_le(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(v[8*i +: 8]);
	endtask

	task automatic put_text(input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(8'($urandom));
	endtask

	// An id header followed by body bytes. Lengths of 255 and up can only be
	// written in the escaped four-byte form.
	task automatic put_id(input logic [31:0] len, input bit escaped, input int body);
		if (escaped || len >= 32'd255) begin
			file_bytes.push_back(ESCAPE_LEN);
			put_le(64'(len), 4);
		end else begin
			file_bytes.push_back(len[7:0]);
		end
		put_text(body);
	endtask

	// Overwrites the header size word, as far as the file reaches it.
	task automatic patch_size(input logic [63:0] w);
		for (int i = 0; i < 8; i++)
			if (1 + i < file_bytes.size())
				file_bytes[1 + i] = w[8*i +: 8];
	endtask

	// Lets every outstanding result drain, then waits on for a byte that is
	// still in flight but produces nothing.
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One slave-side transaction. Gaps are only inserted between bursts, so a
	// valid that stays high is never dropped and raised in the same step.
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Streams the queued file. Files whose size word is reached and that need
	// a different register value wait for the block to go idle first; all
	// others follow the previous file back to back.
	task automatic stream_file(input bit needs_reg, input logic [63:0] reg_val);
		if (needs_reg && reg_val !== size_setting) begin
			settle_idle();
			cfg_we <= 1'b1;
			cfg_wdata <= reg_val;
			@(posedge clk);
			cfg_we <= 1'b0;
			size_setting = reg_val;
		end
		foreach (file_bytes[i])
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		bytes_sent += file_bytes.size();
		file_bytes.delete();
	endtask

	// Mostly well-formed files with random contents, plus legacy files,
	// count and size mismatches, oversized lengths and truncated files.
	task automatic build_random_file(output bit needs_reg, output logic [63:0] reg_val);
		int          n_ids;
		int          roll;
		int          cut;
		logic [31:0] len;
		logic [63:0] count_word;
		logic [63:0] size_word;
		logic [63:0] vol;
		needs_reg = 1'b1;
		reg_val = '0;
		if ($urandom_range(0, 99) < 8) begin
			// Legacy format: any nonzero first byte, trailing bytes ignored.
			file_bytes.push_back(8'($urandom_range(1, 255)));
			put_text($urandom_range(0, 4));
			needs_reg = 1'b0;
		end else begin
			n_ids = $urandom_range(0, 6);
			roll = $urandom_range(0, 99);
			if (roll < 70)
				count_word = 64'(n_ids);
			else if (roll < 80)
				count_word = 64'(n_ids + $urandom_range(1, 3));
			else if (roll < 88)
				count_word = 64'($urandom_range(0, n_ids));
			else if (roll < 94)
				count_word = {$urandom, $urandom};
			else
				count_word = '1;
			file_bytes.push_back(8'h00);
			put_le('0, 8);
			put_le(count_word, 8);
			if ($urandom_range(0, 19) == 0) begin
				// Huge title length: the file must end inside the title.
				put_le(64'({1'b1, 31'($urandom)}), 4);
				put_text($urandom_range(1, 5));
			end else begin
				len = pick_len(8);
				put_le(64'(len), 4);
				put_text(len);
				len = ($urandom_range(0, 24) == 0) ? 32'd255 : pick_len(8);
				file_bytes.push_back(len[7:0]);
				put_text(len);
				roll = $urandom_range(0, 99);
				if (roll < 50)
					vol = '0;
				else if (roll < 70)
					vol = 64'($urandom_range(1, 3));
				else if (roll < 90)
					vol = {$urandom, $urandom};
				else
					vol = '1;
				put_le(vol, 8);
				if (vol != 0) begin
					len = pick_len(6);
					file_bytes.push_back(len[7:0]);
					put_text(len);
					len = pick_len(8);
					put_le(64'(len), 4);
					put_text(len);
				end
				for (int i = 0; i < n_ids; i++) begin
					roll = $urandom_range(0, 99);
					if (roll < 2) begin
						put_id(32'd254, 1'b0, 254);
					end else if (roll < 5) begin
						len = $urandom_range(255, 300);
						put_id(len, 1'b1, len);
					end else begin
						len = pick_len(6);
						put_id(len, roll < 17, len);
					end
				end
				if ($urandom_range(0, 9) == 0)
					put_text($urandom_range(1, 4));
			end
			roll = $urandom_range(0, 99);
			if (roll < 80)
				size_word = 64'(file_bytes.size());
			else if (roll < 88)
				size_word = '1;
			else if (roll < 94)
				size_word = '0;
			else
				size_word = {$urandom, $urandom};
			patch_size(size_word);
			if ($urandom_range(0, 9) == 0)
				reg_val = size_word ^ (64'd1 << $urandom_range(0, 63));
			else
				reg_val = size_word;
			if ($urandom_range(0, 99) < 15) begin
				cut = $urandom_range(1, file_bytes.size() - 1);
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end
			// The size word is never completed, so the register does not matter.
			if (file_bytes.size() < 9)
				needs_reg = 1'b0;
		end
	endtask

	initial begin
		bit          needs_reg;
		logic [63:0] reg_val;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Legacy format with the highest first byte and trailing bytes.
		file_bytes = '{8'hFF, 8'h00, 8'h5A};
		stream_file(1'b0, '0);
		// Legacy format ended on its very first byte.
		file_bytes = '{8'h01};
		stream_file(1'b0, '0);
		// A lone zero format byte: the header is truncated.
		file_bytes = '{8'h00};
		stream_file(1'b0, '0);

		// Size word disagrees with a register of zero; the rest is ignored.
		file_bytes.push_back(8'h00);
		put_le(64'd5, 8);
		put_text(2);
		stream_file(1'b1, '0);

		// Complete file against an all-ones register: empty title, volume
		// section with an empty db date, an empty id, an escaped id, a
		// one-byte id, then bytes past the last id that are ignored.
		file_bytes.push_back(8'h00);
		put_le('1, 8);
		put_le(64'd3, 8);
		put_le(64'd0, 4);
		file_bytes.push_back(8'd2);
		put_text(2);
		put_le(64'd1, 8);
		file_bytes.push_back(8'd0);
		put_le(64'd3, 4);
		put_text(3);
		put_id(32'd0, 1'b0, 0);
		put_id(32'd2, 1'b1, 2);
		put_id(32'd1, 1'b0, 1);
		put_text(2);
		stream_file(1'b1, '1);

		// Two ids announced but only one present: count mismatch.
		file_bytes.push_back(8'h00);
		put_le('0, 8);
		put_le(64'd2, 8);
		put_le(64'd1, 4);
		put_text(1);
		file_bytes.push_back(8'd0);
		put_le(64'd0, 8);
		put_id(32'd1, 1'b0, 1);
		patch_size(64'(file_bytes.size()));
		stream_file(1'b1, 64'(file_bytes.size()));

		// Largest title length, cut short after two bytes.
		file_bytes.push_back(8'h00);
		put_le('0, 8);
		put_le(64'd0, 8);
		put_le(64'hFFFF_FFFF, 4);
		put_text(2);
		patch_size(64'(file_bytes.size()));
		stream_file(1'b1, 64'(file_bytes.size()));

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			build_random_file(needs_reg, reg_val);
			stream_file(needs_reg, reg_val);
		end

		settle_idle();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
